[hdl/bat_pkg.sv]
// shared types and constants of the button auto-repeat tracker
package bat_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPEAT_DETECT = 3'd0,
		CFG_REPEAT_DELAY  = 3'd1,
		CFG_REPEAT_PERIOD = 3'd2,
		CFG_ACTIVE_LEVEL  = 3'd3,
		CFG_QUERY_ENABLE  = 3'd4
	} cfg_idx_t;

	localparam logic [15:0] RST_REPEAT_DETECT = 16'd60;
	localparam logic [15:0] RST_REPEAT_DELAY  = 16'd250;
	localparam logic [15:0] RST_REPEAT_PERIOD = 16'd200;
	localparam logic        RST_ACTIVE_LEVEL  = 1'b0;
	localparam logic        RST_QUERY_ENABLE  = 1'b1;

	typedef struct packed {
		logic [15:0] repeat_detect;
		logic [15:0] repeat_delay;
		logic [15:0] repeat_period;
		logic        active_level;
		logic        query_enable;
	} cfg_t;

	typedef struct packed {
		logic        is_pressed;
		logic        is_released;
		logic        press_pulse;
		logic        release_pulse;
		logic        repeat_pulse;
		logic [15:0] repeat_total;
		logic [31:0] press_ticks;
		logic [31:0] release_ticks;
	} result_t;

endpackage

[hdl/bat_if.sv]
// channel interfaces: sample ticks, results and register writes

interface bat_sample_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface bat_result_if;
	logic        valid;
	logic        ready;
	logic        is_pressed;
	logic        is_released;
	logic        press_pulse;
	logic        release_pulse;
	logic        repeat_pulse;
	logic [15:0] repeat_total;
	logic [31:0] press_ticks;
	logic [31:0] release_ticks;

	modport source (output valid, output is_pressed, output is_released,
		output press_pulse, output release_pulse, output repeat_pulse,
		output repeat_total, output press_ticks, output release_ticks, input ready);
	modport sink (input valid, input is_pressed, input is_released,
		input press_pulse, input release_pulse, input repeat_pulse,
		input repeat_total, input press_ticks, input release_ticks, output ready);
endinterface

interface bat_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/bat_cfg_regs.sv]
// configuration register file
module bat_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [bat_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [bat_pkg::CFG_DATA_W-1:0]  wr_data,
	output bat_pkg::cfg_t                   cfg
);
	import bat_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_detect <= RST_REPEAT_DETECT;
			cfg_q.repeat_delay  <= RST_REPEAT_DELAY;
			cfg_q.repeat_period <= RST_REPEAT_PERIOD;
			cfg_q.active_level  <= RST_ACTIVE_LEVEL;
			cfg_q.query_enable  <= RST_QUERY_ENABLE;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_REPEAT_DETECT: cfg_q.repeat_detect <= wr_data;
				CFG_REPEAT_DELAY:  cfg_q.repeat_delay  <= wr_data;
				CFG_REPEAT_PERIOD: cfg_q.repeat_period <= wr_data;
				CFG_ACTIVE_LEVEL:  cfg_q.active_level  <= wr_data[0];
				CFG_QUERY_ENABLE:  cfg_q.query_enable  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/bat_core.sv]
// tracker state and per-tick update logic
module bat_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pin_level,
	input  bat_pkg::cfg_t    cfg,
	output bat_pkg::result_t res
);
	import bat_pkg::*;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	logic        held_q, release_seen_q;
	logic [15:0] hold_cnt_q, repeat_cnt_q;
	logic [31:0] press_dur_q, release_dur_q;

	logic        held_d, release_seen_d;
	logic [15:0] hold_cnt_d, repeat_cnt_d;
	logic [31:0] press_dur_d, release_dur_d;
	logic        down, p_pulse, r_pulse, rep_pulse;
	logic [15:0] hold_inc, limit;

	always_comb begin
		down     = (pin_level == cfg.active_level);
		hold_inc = sat_inc16(hold_cnt_q);
		if (repeat_cnt_q == 16'd0)
			limit = cfg.repeat_detect;
		else if (repeat_cnt_q == 16'd1)
			limit = cfg.repeat_delay;
		else
			limit = cfg.repeat_period;

		held_d         = held_q;
		release_seen_d = release_seen_q;
		hold_cnt_d     = hold_cnt_q;
		repeat_cnt_d   = repeat_cnt_q;
		press_dur_d    = press_dur_q;
		release_dur_d  = release_dur_q;
		p_pulse        = 1'b0;
		r_pulse        = 1'b0;
		rep_pulse      = 1'b0;

		if (down) begin
			p_pulse        = !held_q;
			press_dur_d    = held_q ? sat_inc32(press_dur_q) : 32'd0;
			held_d         = 1'b1;
			release_seen_d = 1'b0;
			if (hold_inc >= limit) begin
				rep_pulse    = 1'b1;
				hold_cnt_d   = 16'd0;
				repeat_cnt_d = sat_inc16(repeat_cnt_q);
			end else begin
				hold_cnt_d   = hold_inc;
			end
		end else begin
			// hold counter deliberately kept across a release
			r_pulse        = held_q;
			release_dur_d  = held_q ? 32'd0 : sat_inc32(release_dur_q);
			held_d         = 1'b0;
			release_seen_d = 1'b1;
			repeat_cnt_d   = 16'd0;
		end

		res.press_pulse   = p_pulse;
		res.release_pulse = r_pulse;
		res.repeat_pulse  = rep_pulse;
		res.is_pressed    = cfg.query_enable & held_d;
		res.is_released   = cfg.query_enable & release_seen_d;
		res.repeat_total  = cfg.query_enable ? repeat_cnt_d : 16'd0;
		res.press_ticks   = cfg.query_enable ? press_dur_d : 32'd0;
		res.release_ticks = cfg.query_enable ? release_dur_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= 1'b0;
			release_seen_q <= 1'b0;
			hold_cnt_q     <= 16'd0;
			repeat_cnt_q   <= 16'd0;
			press_dur_q    <= 32'd0;
			release_dur_q  <= 32'd0;
		end else if (step) begin
			held_q         <= held_d;
			release_seen_q <= release_seen_d;
			hold_cnt_q     <= hold_cnt_d;
			repeat_cnt_q   <= repeat_cnt_d;
			press_dur_q    <= press_dur_d;
			release_dur_q  <= release_dur_d;
		end
	end

endmodule

[hdl/button_autorepeat_tracker.sv]
// top level: button auto-repeat tracker with registered input and result stages
// a sample waits in the input stage until the result register is free to take it
// throughput: one sample transaction per cycle, limited only by result back-pressure
// the per-tick update is one pass through the core between the two stage registers
// reset: asynchronous active low, clears all counters and flags, loads register defaults
// register writes take effect in the next cycle and are always accepted
module button_autorepeat_tracker (
	input  logic      clk,
	input  logic      arst_n,
	bat_sample_if.sink  sample,
	bat_result_if.source result,
	bat_cfg_if.sink     cfg
);
	import bat_pkg::*;

	cfg_t    cfg_val;
	result_t res_comb;
	result_t res_q;
	logic    s1_valid_q;
	logic    pin_s1;
	logic    out_valid_q;
	logic    advance;

	// register writes never stall
	assign cfg.ready = 1'b1;

	bat_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	// the held tick moves into the result register when that register is free
	assign advance      = s1_valid_q && (!out_valid_q || result.ready);
	// input stage refills in the same cycle that it drains
	assign sample.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sample.ready) begin
			s1_valid_q <= sample.valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pin_s1 <= sample.pin_level;
		end
	end

	// state only moves when its result is captured, so each tick updates it once
	bat_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_s1),
		.cfg       (cfg_val),
		.res       (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.is_pressed    = res_q.is_pressed;
	assign result.is_released   = res_q.is_released;
	assign result.press_pulse   = res_q.press_pulse;
	assign result.release_pulse = res_q.release_pulse;
	assign result.repeat_pulse  = res_q.repeat_pulse;
	assign result.repeat_total  = res_q.repeat_total;
	assign result.press_ticks   = res_q.press_ticks;
	assign result.release_ticks = res_q.release_ticks;

	// a tick cannot both start a press and start a release
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.press_pulse && res_q.release_pulse))
		else $error("press and release pulse in the same result");

	// the press duration restarts at zero on the first held tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.press_pulse) |-> (res_q.press_ticks == 32'd0))
		else $error("press duration not restarted on press");

	// the release duration restarts at zero on the first released tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.release_pulse) |-> (res_q.release_ticks == 32'd0))
		else $error("release duration not restarted on release");

	// the input side only stalls while a full pipeline waits on the result side
	assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (s1_valid_q && out_valid_q && !result.ready))
		else $error("input stalled without result back-pressure");

	// a stalled result keeps the tick in the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !result.ready) |=> s1_valid_q)
		else $error("tick lost from input stage during stall");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the button auto-repeat tracker
`timescale 1ns / 1ps

module tb_top;
	import bat_pkg::*;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	// one step of the directed plan: a sample tick or a register write
	typedef struct {
		row_kind_t   kind;
		cfg_idx_t    reg_idx;
		logic [15:0] value;
		logic        pin;
		bit          typed;
		result_t     want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	bat_sample_if smp ();
	bat_result_if res ();
	bat_cfg_if    cfg_ch ();

	button_autorepeat_tracker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// register copy and tracker state, mirrored on the testbench side
	cfg_t        cfg_shadow;
	logic        trk_held;
	logic        trk_released;
	logic [15:0] trk_hold;
	logic [15:0] trk_repeats;
	logic [31:0] trk_press_len;
	logic [31:0] trk_release_len;

	result_t   due_results[$];
	bit        failed = 1'b0;
	int        gap_odds = 0;
	int        stall_odds = 0;
	int        stall_left = 0;
	plan_row_t plan[34];

	// advance the mirrored tracker by one tick and give the result it should show
	function automatic result_t track_tick(input logic pin);
		result_t     r;
		logic [15:0] limit;
		r = '0;
		if (pin == cfg_shadow.active_level) begin
			// press starts on the first held tick, duration restarts from zero
			if (!trk_held) begin
				r.press_pulse = 1'b1;
				trk_press_len = '0;
			end else if (trk_press_len != 32'hFFFF_FFFF) begin
				trk_press_len++;
			end
			trk_held = 1'b1;
			if (trk_hold != 16'hFFFF)
				trk_hold++;
			// first repeat after detect, second after delay, the rest after period
			if (trk_repeats == 16'd0)
				limit = cfg_shadow.repeat_detect;
			else if (trk_repeats == 16'd1)
				limit = cfg_shadow.repeat_delay;
			else
				limit = cfg_shadow.repeat_period;
			if (trk_hold >= limit) begin
				trk_hold = '0;
				if (trk_repeats != 16'hFFFF)
					trk_repeats++;
				r.repeat_pulse = 1'b1;
			end
			trk_released = 1'b0;
		end else begin
			if (trk_held) begin
				r.release_pulse = 1'b1;
				trk_release_len = '0;
			end else if (trk_release_len != 32'hFFFF_FFFF) begin
				trk_release_len++;
			end
			// hold counter deliberately survives the release
			trk_held = 1'b0;
			trk_released = 1'b1;
			trk_repeats = '0;
		end
		// pulses are never masked, the query fields are
		if (cfg_shadow.query_enable) begin
			r.is_pressed    = trk_held;
			r.is_released   = trk_released;
			r.repeat_total  = trk_repeats;
			r.press_ticks   = trk_press_len;
			r.release_ticks = trk_release_len;
		end
		return r;
	endfunction

	// threshold mix: mostly short, sometimes zero, the maximum or a random full-range value
	function automatic logic [15:0] pick_threshold();
		case ($urandom_range(9, 0))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(65535, 0));
			default: return 16'($urandom_range(12, 1));
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	// one sample transaction, with an occasional idle burst in front of it
	task automatic send_tick(input logic pin, input bit typed, input result_t want);
		result_t predicted;
		int      gap;
		cfg_ch.valid <= 1'b0;
		if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
			gap = $urandom_range(8, 1);
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid     <= 1'b1;
		smp.pin_level <= pin;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		predicted = track_tick(pin);
		due_results.push_back(typed ? want : predicted);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		smp.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// register write; valid stays high until a later sample tick drops it
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_REPEAT_DETECT: cfg_shadow.repeat_detect = val;
			CFG_REPEAT_DELAY:  cfg_shadow.repeat_delay  = val;
			CFG_REPEAT_PERIOD: cfg_shadow.repeat_period = val;
			CFG_ACTIVE_LEVEL:  cfg_shadow.active_level  = val[0];
			CFG_QUERY_ENABLE:  cfg_shadow.query_enable  = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setup(input logic [15:0] detect, input logic [15:0] delay,
		input logic [15:0] period, input logic level, input logic enable);
		settle();
		write_reg(CFG_REPEAT_DETECT, detect);
		write_reg(CFG_REPEAT_DELAY, delay);
		write_reg(CFG_REPEAT_PERIOD, period);
		write_reg(CFG_ACTIVE_LEVEL, {15'd0, level});
		write_reg(CFG_QUERY_ENABLE, {15'd0, enable});
	endtask

	// result side: random stall bursts with ready held low
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (stall_left != 0) begin
			res.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
			res.ready  <= 1'b0;
			stall_left <= $urandom_range(7, 0);
		end else begin
			res.ready <= 1'b1;
		end
	end

	// every accepted result transaction is held against the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (due_results.size() == 0) begin
				$error("result transaction with nothing outstanding");
				failed = 1'b1;
			end else begin
				want = due_results.pop_front();
				check_field("is_pressed", 32'(want.is_pressed), 32'(res.is_pressed));
				check_field("is_released", 32'(want.is_released), 32'(res.is_released));
				check_field("press_pulse", 32'(want.press_pulse), 32'(res.press_pulse));
				check_field("release_pulse", 32'(want.release_pulse),
					32'(res.release_pulse));
				check_field("repeat_pulse", 32'(want.repeat_pulse), 32'(res.repeat_pulse));
				check_field("repeat_total", 32'(want.repeat_total), 32'(res.repeat_total));
				check_field("press_ticks", want.press_ticks, res.press_ticks);
				check_field("release_ticks", want.release_ticks, res.release_ticks);
			end
		end
	end

	initial begin
		int   in_phase;
		int   hold_len;
		int   rel_len;
		logic lvl;

		clk           = 1'b0;
		arst_n        = 1'b0;
		smp.valid     = 1'b0;
		smp.pin_level = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;

		cfg_shadow = '{RST_REPEAT_DETECT, RST_REPEAT_DELAY, RST_REPEAT_PERIOD,
			RST_ACTIVE_LEVEL, RST_QUERY_ENABLE};
		trk_held        = 1'b0;
		trk_released    = 1'b0;
		trk_hold        = '0;
		trk_repeats     = '0;
		trk_press_len   = '0;
		trk_release_len = '0;

		// directed plan; results are typed in where they follow at a glance
		plan = '{
			// idle after reset: release duration counts up from zero
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b1,
				'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd1}},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b1,
				'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd2}},
			// press with the reset active level of 0
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b1,
				'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 32'd0, 32'd2}},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b1,
				'{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0}},
			// zero thresholds: a repeat on every held tick
			'{ROW_WRITE, CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_REPEAT_DELAY,  16'd0, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_REPEAT_PERIOD, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b1,
				'{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 16'd1, 32'd0, 32'd0}},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b1,
				'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd2, 32'd1, 32'd0}},
			// flipping the active level mid-press keeps the press going
			'{ROW_WRITE, CFG_ACTIVE_LEVEL,  16'd1, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b1,
				'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd3, 32'd2, 32'd0}},
			// query masked: only the pulse survives
			'{ROW_WRITE, CFG_QUERY_ENABLE,  16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b1,
				'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0}},
			'{ROW_WRITE, CFG_QUERY_ENABLE,  16'd1, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b1,
				'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'd2, 32'd1}},
			// widest thresholds, hold counter carried over from the last press
			'{ROW_WRITE, CFG_REPEAT_DETECT, 16'hFFFF, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_REPEAT_DELAY,  16'hFFFF, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_REPEAT_PERIOD, 16'hFFFF, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			// short detect, delay and period to walk the three thresholds
			'{ROW_WRITE, CFG_REPEAT_DETECT, 16'd2, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_REPEAT_DELAY,  16'd3, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_REPEAT_PERIOD, 16'd1, 1'b0, 1'b0, '0},
			'{ROW_WRITE, CFG_ACTIVE_LEVEL,  16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b0, 1'b0, '0},
			'{ROW_TICK,  CFG_REPEAT_DETECT, 16'd0, 1'b1, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds   = 4;
		stall_odds = 4;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				send_tick(plan[i].pin, plan[i].typed, plan[i].want);
			end
		end

		// one long press: first repeat at detect, then a repeat on every tick
		lvl = 1'($urandom_range(1, 0));
		apply_setup(16'd20, 16'd0, 16'd0, lvl, 1'b1);
		gap_odds   = 8;
		stall_odds = 8;
		repeat (60) send_tick(lvl, 1'b0, '0);
		repeat (3) send_tick(~lvl, 1'b0, '0);

		// random phases: mostly clean press and release runs, some pin noise
		for (int ph = 0; ph < 10; ph++) begin
			lvl = 1'($urandom_range(1, 0));
			apply_setup(pick_threshold(), pick_threshold(), pick_threshold(), lvl,
				$urandom_range(3, 0) != 0);
			if (ph == 9) begin
				// closing stretch runs flat out on both sides
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				case ($urandom_range(2, 0))
					0: gap_odds = 0;
					1: gap_odds = 8;
					default: gap_odds = 3;
				endcase
				case ($urandom_range(2, 0))
					0: stall_odds = 0;
					1: stall_odds = 8;
					default: stall_odds = 3;
				endcase
			end
			in_phase = 0;
			while (in_phase < 150) begin
				if ($urandom_range(9, 0) < 7) begin
					hold_len = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 40)
						: $urandom_range(40, 1);
					rel_len  = $urandom_range(12, 1);
					repeat (hold_len) send_tick(lvl, 1'b0, '0);
					repeat (rel_len) send_tick(~lvl, 1'b0, '0);
					in_phase += hold_len + rel_len;
				end else begin
					hold_len = $urandom_range(6, 1);
					repeat (hold_len) send_tick(1'($urandom_range(1, 0)), 1'b0, '0);
					in_phase += hold_len;
				end
			end
		end

		settle();
		// room for a stray result transaction to show up
		repeat (8) @(posedge clk);
		if (!failed && due_results.size() == 0)
			$display("button_autorepeat_tracker: match");
		else
			$display("button_autorepeat_tracker: mismatch");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#(40_000_000);
		$display("button_autorepeat_tracker: mismatch");
		$finish;
	end

endmodule
